// ===== rtl/core/lhfs_pkg.sv =====
// Shared types and constants of the length-header frame splitter.
package lhfs_pkg;

    localparam int TransferBytesDef = 2048;
    localparam int LenW = 11;
    localparam int PosFullW = 12;
    localparam logic [LenW-1:0] SizeMask = 11'h7FF;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       transfer_end;
    } t_rx_item;

    typedef struct packed {
        logic [LenW-1:0] frame_offset;
        logic [LenW-1:0] frame_length;
    } t_frame_item;

endpackage

// ===== rtl/core/lhfs_stream_if.sv =====
// Valid/ready stream interface that carries one payload per transaction.
interface lhfs_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/length_header_frame_splitter.sv =====
// Top level of the length-header frame splitter: header check, payload count, descriptor output.
// The transaction carrying the last payload byte registers its descriptor into the output stage.
// Throughput: one byte per cycle; a two-entry output stage keeps the input open while a
// descriptor waits, so the input stalls only when both entries are full.
// Reset: synchronous, active low; clears the parse state and empties the output stage.
// The marked last byte of a transfer also returns the parse state to its reset value.
module length_header_frame_splitter
    import lhfs_pkg::*;
#(
    parameter int TRANSFER_BYTES = TransferBytesDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lhfs_stream_if.sink   i_rx,
    lhfs_stream_if.source o_frame
);

    localparam int PosW = $clog2(TRANSFER_BYTES + 1);
    localparam logic [PosW-1:0] PosLimit = PosW'(TRANSFER_BYTES);

    localparam logic [1:0] PhHeader  = 2'd0;
    localparam logic [1:0] PhPayload = 2'd1;
    localparam logic [1:0] PhPad     = 2'd2;
    localparam logic [1:0] PhDiscard = 2'd3;

    logic [1:0]      r_phase, n_phase;
    logic [1:0]      r_hdr_cnt, n_hdr_cnt;
    logic [LenW-1:0] r_hdr_lo, n_hdr_lo;
    logic [7:0]      r_hdr_b2, n_hdr_b2;
    logic [LenW-1:0] r_cur_len, n_cur_len;
    logic [LenW-1:0] r_remain, n_remain;
    logic [LenW-1:0] r_start, n_start;
    logic [PosW-1:0] r_pos, n_pos;

    t_frame_item r_out, r_skid;
    logic        r_out_valid, r_skid_valid;

    logic            w_accept;
    logic            w_out_fire;
    logic            w_res_valid;
    t_frame_item     w_res;
    logic [LenW-1:0] w_chk;
    logic [LenW-1:0] w_rem_dec;
    logic [PosW-1:0] w_pos_inc;

    assign w_accept   = i_rx.valid && i_rx.ready;
    assign w_out_fire = r_out_valid && o_frame.ready;
    assign i_rx.ready = !r_skid_valid;
    assign o_frame.valid   = r_out_valid;
    assign o_frame.payload = r_out;

    assign w_chk     = ~{i_rx.payload.rx_byte[2:0], r_hdr_b2};
    assign w_rem_dec = r_remain - LenW'(1);
    assign w_pos_inc = r_pos + PosW'(1);

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr_lo    = r_hdr_lo;
        n_hdr_b2    = r_hdr_b2;
        n_cur_len   = r_cur_len;
        n_remain    = r_remain;
        n_start     = r_start;
        n_pos       = r_pos;
        w_res_valid = 1'b0;
        w_res.frame_offset = r_start;
        w_res.frame_length = r_cur_len;
        if (r_pos >= PosLimit) begin
            n_phase = PhDiscard;
        end else begin
            case (r_phase)
                PhHeader: begin
                    case (r_hdr_cnt)
                        2'd0: begin
                            n_hdr_lo[7:0] = i_rx.payload.rx_byte;
                            n_hdr_cnt     = 2'd1;
                        end
                        2'd1: begin
                            n_hdr_lo[LenW-1:8] = i_rx.payload.rx_byte[2:0];
                            n_hdr_cnt          = 2'd2;
                        end
                        2'd2: begin
                            n_hdr_b2  = i_rx.payload.rx_byte;
                            n_hdr_cnt = 2'd3;
                        end
                        default: begin
                            n_hdr_cnt = 2'd0;
                            n_hdr_lo  = '0;
                            n_hdr_b2  = '0;
                            if (r_hdr_lo != w_chk || r_hdr_lo == '0) begin
                                n_phase = PhDiscard;
                            end else begin
                                n_cur_len = r_hdr_lo;
                                n_remain  = r_hdr_lo;
                                n_start   = LenW'(PosFullW'(w_pos_inc)) & SizeMask;
                                n_phase   = PhPayload;
                            end
                        end
                    endcase
                end
                PhPayload: begin
                    n_remain = w_rem_dec;
                    if (w_rem_dec == '0) begin
                        w_res_valid = 1'b1;
                        n_phase     = r_cur_len[0] ? PhPad : PhHeader;
                    end
                end
                PhPad: begin
                    n_phase = PhHeader;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
            n_pos = w_pos_inc;
        end
        if (i_rx.payload.transfer_end) begin
            n_phase   = PhHeader;
            n_hdr_cnt = '0;
            n_hdr_lo  = '0;
            n_hdr_b2  = '0;
            n_cur_len = '0;
            n_remain  = '0;
            n_start   = '0;
            n_pos     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PhHeader;
            r_hdr_cnt <= '0;
            r_hdr_lo  <= '0;
            r_hdr_b2  <= '0;
            r_cur_len <= '0;
            r_remain  <= '0;
            r_start   <= '0;
            r_pos     <= '0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_hdr_lo  <= n_hdr_lo;
            r_hdr_b2  <= n_hdr_b2;
            r_cur_len <= n_cur_len;
            r_remain  <= n_remain;
            r_start   <= n_start;
            r_pos     <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept && w_res_valid) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out <= r_skid;
            end
        end else if (w_accept && w_res_valid) begin
            if (!r_out_valid || w_out_fire) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

endmodule

// ===== rtl/core/lhfs_checker.sv =====
// Port-level assertions for the length-header frame splitter, bound to its top level.
module lhfs_checker
    import lhfs_pkg::*;
#(
    parameter int TRANSFER_BYTES = TransferBytesDef
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic [LenW-1:0] i_frame_offset,
    input logic [LenW-1:0] i_frame_length
);

    localparam logic [PosFullW-1:0] Limit = PosFullW'(TRANSFER_BYTES);

    logic [PosFullW-1:0] w_frame_end;
    assign w_frame_end = PosFullW'(i_frame_offset) + PosFullW'(i_frame_length);

    // A waiting descriptor is held until the sink takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("descriptor withdrawn before its transaction completed");

    // A new descriptor only follows an accepted input transaction.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("descriptor appeared without an input transaction");

    // A frame is never empty and starts after a full four-byte header.
    a_frame_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_frame_length != '0 && i_frame_offset >= LenW'(4))
        else $error("descriptor with empty frame or offset inside the header");

    // The whole frame lies inside the transfer.
    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> w_frame_end <= Limit)
        else $error("descriptor reaches past the end of the transfer");

    // The input is closed only while a descriptor waits at the output.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled while no descriptor is waiting");

endmodule

bind length_header_frame_splitter lhfs_checker #(
    .TRANSFER_BYTES(TRANSFER_BYTES)
) u_lhfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_rx.valid),
    .i_in_ready     (i_rx.ready),
    .i_out_valid    (o_frame.valid),
    .i_out_ready    (o_frame.ready),
    .i_frame_offset (o_frame.payload.frame_offset),
    .i_frame_length (o_frame.payload.frame_length)
);

// ===== tb/length_header_frame_splitter_test.sv =====
// Self-checking testbench of the length-header frame splitter with a frame descriptor scoreboard.
module length_header_frame_splitter_test;
    import lhfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int XferBytes = TransferBytesDef;
    localparam int StallCycles = 500;

    typedef enum logic [1:0] {
        PARSE_HEADER,
        PARSE_PAYLOAD,
        PARSE_PAD,
        PARSE_DISCARD
    } t_parse_phase;

    class frame_scoreboard;
        t_parse_phase        phase;
        logic [1:0]          hdr_count;
        logic [23:0]         hdr_held;
        logic [LenW-1:0]     cur_len;
        logic [LenW-1:0]     remaining;
        logic [LenW-1:0]     start_ofs;
        logic [PosFullW-1:0] position;
        t_frame_item         pending_q[$];
        int                  errors;

        function new();
            errors = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase = PARSE_HEADER;
            hdr_count = '0;
            hdr_held = '0;
            cur_len = '0;
            remaining = '0;
            start_ofs = '0;
            position = '0;
        endfunction

        function void note_byte(t_rx_item it);
            logic [15:0]     lo;
            logic [15:0]     hi;
            logic [LenW-1:0] size;
            logic [LenW-1:0] chk;
            t_frame_item     desc;
            if (position >= XferBytes) begin
                phase = PARSE_DISCARD;
            end else begin
                case (phase)
                    PARSE_HEADER: begin
                        if (hdr_count < 2'd3) begin
                            hdr_held[8*hdr_count +: 8] = it.rx_byte;
                            hdr_count = hdr_count + 2'd1;
                        end else begin
                            lo = hdr_held[15:0];
                            hi = {it.rx_byte, hdr_held[23:16]};
                            size = lo[LenW-1:0];
                            chk = ~hi[LenW-1:0];
                            hdr_count = '0;
                            hdr_held = '0;
                            if (size != chk || size == '0) begin
                                phase = PARSE_DISCARD;
                            end else begin
                                cur_len = size;
                                remaining = size;
                                start_ofs = position[LenW-1:0] + 1'b1;
                                phase = PARSE_PAYLOAD;
                            end
                        end
                    end
                    PARSE_PAYLOAD: begin
                        remaining = remaining - 1'b1;
                        if (remaining == '0) begin
                            desc.frame_offset = start_ofs;
                            desc.frame_length = cur_len;
                            pending_q.push_back(desc);
                            phase = cur_len[0] ? PARSE_PAD : PARSE_HEADER;
                        end
                    end
                    PARSE_PAD: begin
                        phase = PARSE_HEADER;
                    end
                    default: begin
                    end
                endcase
                position = position + 1'b1;
            end
            if (it.transfer_end) begin
                clear_parse();
            end
        endfunction

        function void check_frame(t_frame_item got);
            t_frame_item want;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected descriptor: offset %0d length %0d",
                             got.frame_offset, got.frame_length);
                end
            end else begin
                want = pending_q.pop_front();
                if (got.frame_offset !== want.frame_offset
                        || got.frame_length !== want.frame_length) begin
                    errors++;
                    if (errors <= 10) begin
                        $display({"Descriptor mismatch: expected offset %0d length %0d,",
                                  " got offset %0d length %0d"},
                                 want.frame_offset, want.frame_length,
                                 got.frame_offset, got.frame_length);
                    end
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lhfs_stream_if #(.t_payload(t_rx_item))    rx_if ();
    lhfs_stream_if #(.t_payload(t_frame_item)) frame_if ();

    length_header_frame_splitter #(
        .TRANSFER_BYTES(XferBytes)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_frame (frame_if)
    );

    frame_scoreboard board = new();
    logic [7:0]      xfer[$];
    int              send_idle = 20;
    int              recv_idle = 81;
    bit              stall_request = 1'b0;
    int              hold_left = 0;
    int              bytes_sent = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && frame_if.valid && frame_if.ready) begin
            board.check_frame(frame_if.payload);
        end
        if (stall_request) begin
            stall_request = 1'b0;
            hold_left = StallCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            frame_if.ready <= 1'b0;
        end else begin
            frame_if.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic send_transfer();
        t_rx_item it;
        for (int i = 0; i < xfer.size(); i++) begin
            it.rx_byte = xfer[i];
            it.transfer_end = (i == xfer.size() - 1);
            rx_if.payload <= it;
            rx_if.valid <= 1'b1;
            @(posedge i_clk);
            while (!rx_if.ready) begin
                @(posedge i_clk);
            end
            board.note_byte(it);
            bytes_sent++;
            while ($urandom_range(0, 99) < send_idle) begin
                rx_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    function automatic void push_header(logic [LenW-1:0] size, bit corrupt);
        logic [LenW-1:0] chk;
        logic [15:0]     lo;
        logic [15:0]     hi;
        chk = ~size;
        if (corrupt) begin
            chk[$urandom_range(0, LenW-1)] ^= 1'b1;
        end
        lo = {5'($urandom), size};
        hi = {5'($urandom), chk};
        xfer.push_back(lo[7:0]);
        xfer.push_back(lo[15:8]);
        xfer.push_back(hi[7:0]);
        xfer.push_back(hi[15:8]);
    endfunction

    function automatic void push_noise(int count);
        for (int i = 0; i < count; i++) begin
            xfer.push_back(8'($urandom));
        end
    endfunction

    function automatic void push_record(int size, bit with_pad);
        push_header(LenW'(size), 1'b0);
        push_noise(size);
        if (with_pad && size[0]) begin
            push_noise(1);
        end
    endfunction

    function automatic void build_random_transfer();
        int kind;
        int size;
        kind = $urandom_range(0, 99);
        xfer.delete();
        if (kind >= 92) begin
            push_noise($urandom_range(1, 30));
        end else begin
            for (int r = $urandom_range(1, 5); r > 0; r--) begin
                size = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 300)
                                                    : $urandom_range(1, 24);
                push_record(size, 1'b1);
            end
            if (kind >= 87) begin
                push_record(2 * $urandom_range(0, 10) + 1, 1'b0);
            end else if (kind >= 82) begin
                push_header('0, 1'b0);
                push_noise($urandom_range(0, 8));
            end else if (kind >= 74) begin
                push_header(LenW'($urandom_range(1, 40)), 1'b1);
                push_noise($urandom_range(0, 8));
                if ($urandom_range(0, 1)) begin
                    push_record($urandom_range(1, 8), 1'b1);
                end
            end else if (kind >= 68) begin
                push_noise($urandom_range(1, 3));
            end else if (kind >= 60) begin
                size = $urandom_range(2, 30);
                push_header(LenW'(size), 1'b0);
                push_noise($urandom_range(0, size - 1));
            end
        end
    endfunction

    initial begin
        i_rst_n <= 1'b0;
        rx_if.valid <= 1'b0;
        rx_if.payload <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        xfer = {8'h02, 8'h00, 8'hFD, 8'hFF, 8'h00, 8'hFF,
                8'h01, 8'hF8, 8'hFE, 8'h07, 8'h80, 8'h7F};
        send_transfer();
        xfer = {8'h03, 8'h00, 8'hFC, 8'hF8};
        send_transfer();
        xfer = {8'h00, 8'h00, 8'hFF, 8'hFF};
        send_transfer();
        xfer = {8'h05, 8'h00};
        send_transfer();
        xfer = {8'h03, 8'h00, 8'hFC, 8'hFF, 8'h01, 8'h02};
        send_transfer();

        stall_request = 1'b1;
        while (bytes_sent < 378) begin
            build_random_transfer();
            send_transfer();
        end

        send_idle = 81;
        recv_idle = 20;
        while (bytes_sent < 728) begin
            build_random_transfer();
            send_transfer();
        end

        send_idle = 0;
        recv_idle = 0;
        while (bytes_sent < 1050) begin
            build_random_transfer();
            send_transfer();
        end
        rx_if.valid <= 1'b0;

        while (board.pending_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/lhfs_pkg.sv
rtl/core/lhfs_stream_if.sv
rtl/core/length_header_frame_splitter.sv
rtl/core/lhfs_checker.sv
tb/length_header_frame_splitter_test.sv
